// ===== rtl/multiplexed_segment_clock_macros.svh =====
// Assertion macros used by the checker of the multiplexed segment clock.
`ifndef MULTIPLEXED_SEGMENT_CLOCK_MACROS_SVH
`define MULTIPLEXED_SEGMENT_CLOCK_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MSCL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MSCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mscl_pkg.sv =====
// Types, constants and decode functions of the multiplexed segment clock.
package mscl_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_SECOND = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_SAMPLES = 1'd1;

   localparam logic [7:0] TICKS_PER_SECOND_RESET = 8'd248;
   localparam logic [3:0] DEBOUNCE_SAMPLES_RESET = 4'd4;
   localparam logic [5:0] MINUTES_RESET          = 6'd59;
   localparam logic [5:0] SIXTY                  = 6'd60;
   localparam logic [3:0] LAST_HOUR              = 4'd11;
   localparam logic [2:0] PHASE_LAST             = 3'd6;

   // Active-low digit enables, bit 0 is the hours tens digit.
   localparam logic [3:0] EN_HOURS_TENS   = 4'hE;
   localparam logic [3:0] EN_HOURS_UNITS  = 4'hD;
   localparam logic [3:0] EN_MINUTE_TENS  = 4'hB;
   localparam logic [3:0] EN_MINUTE_UNITS = 4'h7;

   localparam logic [6:0] SEG_BLANK = 7'h7F;

   typedef struct packed {
      logic button_min_n;
      logic button_hour_n;
   } req_type;

   typedef struct packed {
      logic [3:0] digit_enable_n;
      logic [6:0] segments_n;
      logic [3:0] hours_now;
      logic [5:0] minutes_now;
   } rsp_type;

   typedef struct packed {
      logic [7:0] ticks_per_second;
      logic [3:0] debounce_samples;
   } cfg_type;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] units;
   } digits_type;

   function automatic logic [3:0] next_hour(input logic [3:0] h);
      return (h >= LAST_HOUR) ? 4'd0 : h + 4'd1;
   endfunction

   // Active-low common-anode pattern, bit 0 is segment A.
   function automatic logic [6:0] seg_of(input logic [3:0] d);
      logic [6:0] s;
      unique case (d)
         4'd0:    s = 7'h40;
         4'd1:    s = 7'h79;
         4'd2:    s = 7'h24;
         4'd3:    s = 7'h30;
         4'd4:    s = 7'h19;
         4'd5:    s = 7'h12;
         4'd6:    s = 7'h02;
         4'd7:    s = 7'h78;
         4'd8:    s = 7'h00;
         4'd9:    s = 7'h10;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   function automatic digits_type split_hours(input logic [3:0] h);
      digits_type r;
      r.tens  = (h >= 4'd10) ? 4'd1 : 4'd0;
      r.units = (h >= 4'd10) ? h - 4'd10 : h;
      return r;
   endfunction

   // Minutes are at most 59 here, so a short compare chain finds the tens.
   function automatic digits_type split_minutes(input logic [5:0] m);
      digits_type r;
      logic [5:0] base;
      priority if (m >= 6'd50) begin
         r.tens = 4'd5;
         base   = 6'd50;
      end else if (m >= 6'd40) begin
         r.tens = 4'd4;
         base   = 6'd40;
      end else if (m >= 6'd30) begin
         r.tens = 4'd3;
         base   = 6'd30;
      end else if (m >= 6'd20) begin
         r.tens = 4'd2;
         base   = 6'd20;
      end else if (m >= 6'd10) begin
         r.tens = 4'd1;
         base   = 6'd10;
      end else begin
         r.tens = 4'd0;
         base   = 6'd0;
      end
      r.units = 4'(m - base);
      return r;
   endfunction

endpackage

// ===== rtl/multiplexed_segment_clock.sv =====
// Top level of the multiplexed four-digit 12-hour segment clock.
//
// Each request word is one timer tick carrying a sample of the two active-low
// set buttons; each tick yields exactly one response word with the digit
// enable, the segment pattern of that digit and the current hour and minute.
// A word is taken into an input register, passes once through the debouncers
// and the time and display logic, and lands in the response register; while
// the response is not stalled, a new request is accepted as the previous one
// moves on, and one word per clock cycle is sustained. The response register
// is the only buffer on the output side: while it holds a stalled word, the
// input register keeps its word, and req_stall is high while both registers
// hold a word and the response is stalled. Configuration writes through the
// csr_ port are always ready and take effect once registered; they are
// meant to happen only while no word is in flight. Register 0 sets the tick
// count that advances seconds (zero means every tick), register 1 the number
// of consecutive differing samples a button needs before its new level counts.
module multiplexed_segment_clock (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mscl_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mscl_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mscl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mscl_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic              in_valid_ff, in_valid_in;
   mscl_pkg::req_type in_data_ff, in_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mscl_pkg::rsp_type rsp_data_ff, rsp_data_in;
   mscl_pkg::cfg_type cfg_ff, cfg_in;

   logic              accept;
   logic              advance;
   logic              min_press, hour_press;
   mscl_pkg::rsp_type result;

   // The word in the input register moves on whenever the response register
   // is empty or is being emptied in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end

      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mscl_pkg::CSR_TICKS_PER_SECOND: cfg_in.ticks_per_second = csr_data;
            mscl_pkg::CSR_DEBOUNCE_SAMPLES: cfg_in.debounce_samples = csr_data[3:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                  <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
         cfg_ff.ticks_per_second      <= mscl_pkg::TICKS_PER_SECOND_RESET;
         cfg_ff.debounce_samples      <= mscl_pkg::DEBOUNCE_SAMPLES_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The minute and hour buttons are debounced side by side; both act on
   // the same tick.
   mscl_debounce u_debounce_min (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .raw_n   (in_data_ff.button_min_n),
      .samples (cfg_ff.debounce_samples),
      .press   (min_press)
   );

   mscl_debounce u_debounce_hour (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .raw_n   (in_data_ff.button_hour_n),
      .samples (cfg_ff.debounce_samples),
      .press   (hour_press)
   );

   mscl_timekeeper u_timekeeper (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .min_press        (min_press),
      .hour_press       (hour_press),
      .ticks_per_second (cfg_ff.ticks_per_second),
      .result           (result)
   );

endmodule

// ===== rtl/mscl_debounce.sv =====
// Debouncer for one active-low button; flags a newly accepted press.
module mscl_debounce (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       raw_n,
   input  logic [3:0] samples,
   output logic       press
);

   logic       stable_ff, stable_in;
   logic [3:0] count_ff, count_in;
   logic       pressed;
   logic [3:0] count_inc;

   always_comb begin
      pressed   = ~raw_n;
      count_inc = count_ff + 4'd1;
      stable_in = stable_ff;
      count_in  = count_ff;
      press     = 1'b0;
      if (pressed != stable_ff) begin
         if (count_inc >= samples) begin
            stable_in = pressed;
            count_in  = 4'd0;
            press     = pressed;
         end else begin
            count_in = count_inc;
         end
      end else begin
         count_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         count_ff  <= 4'd0;
      end else if (advance) begin
         stable_ff <= stable_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/mscl_timekeeper.sv =====
// Time counters, prescaler and display multiplexing of the segment clock.
module mscl_timekeeper (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              min_press,
   input  logic              hour_press,
   input  logic [7:0]        ticks_per_second,
   output mscl_pkg::rsp_type result
);

   logic [7:0] tick_ff, tick_in;
   logic [2:0] phase_ff, phase_in;
   logic [5:0] sec_ff, sec_in;
   logic [5:0] min_ff, min_in;
   logic [3:0] hour_ff, hour_in;

   logic [5:0] min_set, min_carry;
   logic [3:0] hour_set;
   logic [5:0] sec_roll;
   logic [2:0] phase_inc;
   logic [7:0] tick_inc;
   logic [3:0] digit;
   logic [3:0] enable_n;
   mscl_pkg::digits_type hour_digits, min_digits;

   always_comb begin
      // Button presses first, then the second and minute rollovers.
      min_set  = min_press ? min_ff + 6'd1 : min_ff;
      hour_set = hour_press ? mscl_pkg::next_hour(hour_ff) : hour_ff;

      if (sec_ff >= mscl_pkg::SIXTY) begin
         sec_roll  = 6'd0;
         min_carry = min_set + 6'd1;
      end else begin
         sec_roll  = sec_ff;
         min_carry = min_set;
      end

      if (min_carry >= mscl_pkg::SIXTY) begin
         min_in  = 6'd0;
         hour_in = mscl_pkg::next_hour(hour_set);
      end else begin
         min_in  = min_carry;
         hour_in = hour_set;
      end

      hour_digits = mscl_pkg::split_hours(hour_in);
      min_digits  = mscl_pkg::split_minutes(min_in);

      // The phase runs 1 to 6: the hours tens and minute units digits are lit
      // for one tick each, the hours units and minute tens for two.
      phase_inc = phase_ff + 3'd1;
      phase_in  = (phase_inc >= mscl_pkg::PHASE_LAST) ? 3'd0 : phase_inc;
      unique case (phase_inc)
         3'd0, 3'd1: begin
            enable_n = mscl_pkg::EN_HOURS_TENS;
            digit    = hour_digits.tens;
         end
         3'd2, 3'd3: begin
            enable_n = mscl_pkg::EN_HOURS_UNITS;
            digit    = hour_digits.units;
         end
         3'd4, 3'd5: begin
            enable_n = mscl_pkg::EN_MINUTE_TENS;
            digit    = min_digits.tens;
         end
         default: begin
            enable_n = mscl_pkg::EN_MINUTE_UNITS;
            digit    = min_digits.units;
         end
      endcase

      // The prescaler runs last; its second shows up in the next word.
      tick_inc = tick_ff + 8'd1;
      if (tick_inc >= ticks_per_second) begin
         tick_in = 8'd0;
         sec_in  = sec_roll + 6'd1;
      end else begin
         tick_in = tick_inc;
         sec_in  = sec_roll;
      end

      result.digit_enable_n = enable_n;
      result.segments_n     = mscl_pkg::seg_of(digit);
      result.hours_now      = hour_in;
      result.minutes_now    = min_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= 8'd0;
         phase_ff <= 3'd0;
         sec_ff   <= 6'd0;
         min_ff   <= mscl_pkg::MINUTES_RESET;
         hour_ff  <= 4'd0;
      end else if (advance) begin
         tick_ff  <= tick_in;
         phase_ff <= phase_in;
         sec_ff   <= sec_in;
         min_ff   <= min_in;
         hour_ff  <= hour_in;
      end
   end

endmodule

// ===== rtl/mscl_checker.sv =====
// Port-level checker of the segment clock and its bind to the top level.
`include "multiplexed_segment_clock_macros.svh"

module mscl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mscl_pkg::rsp_type rsp_data
);

   // A stalled response word stays valid and unchanged.
   `MSCL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response word changed")

   // Exactly one digit is lit in every response word.
   `MSCL_ASSERT_NOW(a_one_digit, clock, reset, rsp_valid, $onehot(~rsp_data.digit_enable_n), "digit enable is not one-hot")

   // Hour and minute are always in the 12-hour range.
   `MSCL_ASSERT_NOW(a_time_range, clock, reset, rsp_valid, (rsp_data.hours_now <= 4'd11) && (rsp_data.minutes_now <= 6'd59), "time out of range")

   // With the response register empty, the input side never stalls.
   `MSCL_ASSERT_NOW(a_no_stall_empty, clock, reset, !rsp_valid, !req_stall, "request stalled with empty response register")

endmodule

bind multiplexed_segment_clock mscl_checker u_checker (.*);
